>>> rtl/core/sfa_pkg.sv
package sfa_pkg;

  localparam int unsigned BUFFER_DEPTH_DEFAULT = 64;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned TIMER_W    = 9;
  localparam int unsigned CFG_W      = 8;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [CFG_W-1:0] IDLE_LIMIT_RESET  = 8'd30;
  localparam logic [CFG_W-1:0] TICK_LENGTH_RESET = 8'd1;

  localparam logic CFG_IDLE_LIMIT  = 1'b0;
  localparam logic CFG_TICK_LENGTH = 1'b1;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic CAUSE_TERMINATOR = 1'b0;
  localparam logic CAUSE_TIMEOUT    = 1'b1;

  localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } sfa_state_e;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic step;
  } sfa_cmd_t;

  typedef struct packed {
    logic close;
    logic last;
  } sfa_stat_t;

endpackage

>>> rtl/core/serial_frame_assembler_idle_timeout.sv
// Collects received bytes and tick beats into frames. A beat on the input stream carries a
// received byte (tuser 0) or a tick (tuser 1) and is taken while no frame is being sent. A
// terminator byte (NUL, LF or CR) or an idle timeout closes the frame, which then leaves as
// a run of beats, tlast on the final one; each beat is read from the buffer memory into the
// output register and held there until the sink takes it. The input stays blocked until
// the last beat is taken. Bytes arriving with the buffer full are dropped.
module serial_frame_assembler_idle_timeout #(
  parameter int unsigned BUFFER_DEPTH = sfa_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [sfa_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // Fields from bit 0: data_byte.
  input  logic [sfa_pkg::BYTE_W-1:0]     s_axis_tdata_i,
  // Fields from bit 0: command.
  input  logic                           s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // Fields from bit 0: frame_byte, frame_length.
  output logic [sfa_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                           m_axis_tlast_o,
  // Fields from bit 0: end_cause.
  output logic                           m_axis_tuser_o
);
  import sfa_pkg::*;

  sfa_cmd_t          cmd;
  sfa_stat_t         stat;
  logic [BYTE_W-1:0] frame_byte;
  logic [LEN_W-1:0]  frame_length;
  logic              end_cause;

  sfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sfa_dp #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_command_i   (s_axis_tuser_i),
    .in_byte_i      (s_axis_tdata_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .frame_byte_o   (frame_byte),
    .frame_length_o (frame_length),
    .end_cause_o    (end_cause)
  );

  assign m_axis_tlast_o = stat.last;
  assign m_axis_tdata_o = {{(OUT_DATA_W - LEN_W - BYTE_W){1'b0}}, frame_length, frame_byte};
  assign m_axis_tuser_o = end_cause;

endmodule

>>> rtl/core/sfa_ctrl.sv
module sfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sfa_pkg::sfa_stat_t stat_i,
  output sfa_pkg::sfa_cmd_t  cmd_o
);
  import sfa_pkg::*;

  sfa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && stat_i.close) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_SEND;
      end
      ST_SEND: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.step = 1'b1;
          state_d    = stat_i.last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/sfa_dp.sv
module sfa_dp #(
  parameter int unsigned BUFFER_DEPTH = sfa_pkg::BUFFER_DEPTH_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [sfa_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       in_command_i,
  input  logic [sfa_pkg::BYTE_W-1:0] in_byte_i,
  input  sfa_pkg::sfa_cmd_t          cmd_i,
  output sfa_pkg::sfa_stat_t         stat_o,
  output logic [sfa_pkg::BYTE_W-1:0] frame_byte_o,
  output logic [sfa_pkg::LEN_W-1:0]  frame_length_o,
  output logic                       end_cause_o
);
  import sfa_pkg::*;

  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned IW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic [BYTE_W-1:0]  mem [BUFFER_DEPTH];
  logic [CFG_W-1:0]   limit_q, tick_q;
  logic [CW-1:0]      count_q, count_d, len_q;
  logic [TIMER_W-1:0] timer_q, timer_d, timer_add;
  logic [TIMER_W:0]   timer_sum;
  logic [IW-1:0]      rd_idx_q;
  logic [BYTE_W-1:0]  rdata_q;
  logic               cause_q, cause_d;
  logic               full, term, store, close, close_hit;

  assign full      = (count_q == CW'(BUFFER_DEPTH));
  assign term      = (in_byte_i == CHAR_NUL) || (in_byte_i == CHAR_LF) || (in_byte_i == CHAR_CR);
  assign store     = cmd_i.accept && (in_command_i == CMD_BYTE) && !full;
  assign timer_sum = {1'b0, timer_q} + (TIMER_W + 1)'(tick_q);
  assign timer_add = timer_sum[TIMER_W] ? '1 : timer_sum[TIMER_W-1:0];
  assign close_hit = (in_command_i == CMD_BYTE) ? (!full && term)
                   : ((count_q != '0) && (timer_add >= TIMER_W'(limit_q)));

  always_comb begin
    count_d = count_q;
    timer_d = timer_q;
    cause_d = cause_q;
    close   = 1'b0;
    if (cmd_i.accept) begin
      if (in_command_i == CMD_BYTE) begin
        if (!full) begin
          count_d = count_q + 1'b1;
          timer_d = '0;
          if (term) begin
            close   = 1'b1;
            cause_d = CAUSE_TERMINATOR;
          end
        end
      end else if (count_q == '0) begin
        timer_d = '0;
      end else begin
        timer_d = timer_add;
        if (timer_add >= TIMER_W'(limit_q)) begin
          close   = 1'b1;
          cause_d = CAUSE_TIMEOUT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= IDLE_LIMIT_RESET;
      tick_q   <= TICK_LENGTH_RESET;
      count_q  <= '0;
      timer_q  <= '0;
      len_q    <= '0;
      rd_idx_q <= '0;
      cause_q  <= CAUSE_TERMINATOR;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_IDLE_LIMIT:  limit_q <= cfg_wdata_i;
          CFG_TICK_LENGTH: tick_q  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      cause_q <= cause_d;
      if (close) begin
        len_q    <= count_d;
        count_q  <= '0;
        timer_q  <= '0;
        rd_idx_q <= '0;
      end else begin
        count_q <= count_d;
        timer_q <= timer_d;
        if (cmd_i.step) begin
          rd_idx_q <= rd_idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      mem[count_q[IW-1:0]] <= in_byte_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_idx_q];
    end
  end

  assign stat_o.close   = close_hit;
  assign stat_o.last    = ((CW'(rd_idx_q) + 1'b1) == len_q);
  assign frame_byte_o   = rdata_q;
  assign frame_length_o = LEN_W'(len_q);
  assign end_cause_o    = cause_q;

endmodule

>>> rtl/core/sfa_checker.sv
module sfa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [sfa_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                           m_axis_tlast_o,
  input logic                           m_axis_tuser_o
);
  import sfa_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o)))
    else $error("Output beat changed while stalled.");

  a_no_input_while_sending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("Input taken while a frame is being sent.");

  a_length_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[BYTE_W +: LEN_W] != '0))
    else $error("Frame sent with zero length.");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> !m_axis_tvalid_o)
    else $error("Beat followed the last beat of a frame.");

endmodule

bind serial_frame_assembler_idle_timeout sfa_checker u_sfa_checker (.*);
